/* hdl/kfc_pkg.sv */
package kfc_pkg;

  // Width of the entry register, the accumulator and the serial datapath.
  localparam int VALUE_WIDTH = 16;
  // Step counter of the serial unit: counts VALUE_WIDTH-1 down to 0.
  localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  // Key codes
  localparam logic [7:0] KEY_ONE    = 8'd1;
  localparam logic [7:0] KEY_ZERO   = 8'd10;
  localparam logic [7:0] KEY_ADD    = 8'd11;
  localparam logic [7:0] KEY_EQUALS = 8'd15;

  // Pending operator codes
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  // Event kinds
  localparam logic [1:0] EV_IGNORED = 2'd0;
  localparam logic [1:0] EV_DIGIT   = 2'd1;
  localparam logic [1:0] EV_OPER    = 2'd2;
  localparam logic [1:0] EV_RESULT  = 2'd3;

  localparam logic [VALUE_WIDTH-1:0] TEN = VALUE_WIDTH'(10);

  // Serial unit operations
  typedef enum logic [1:0] {
    ALU_MAC,  // p_init + a * b, one multiplier bit per cycle
    ALU_ADD,  // a + b, one bit per cycle
    ALU_SUB,  // a - b, one bit per cycle
    ALU_DIV   // a / b, one quotient bit per cycle
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

  // Fit a datapath value onto a 16-bit result field.
  function automatic logic [15:0] fit16(input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH+15:0] ext;
    ext = {16'b0, v};
    return ext[15:0];
  endfunction

endpackage

/* hdl/kfc_if.sv */
interface kfc_key_if import kfc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

interface kfc_res_if import kfc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [3:0]  shown_digit;
  logic [2:0]  operator_code;
  logic [15:0] result_value;
  logic [15:0] entry_value;

  modport source (output valid, output event_kind, output shown_digit,
                  output operator_code, output result_value, output entry_value,
                  input ready);
  modport sink   (input valid, input event_kind, input shown_digit,
                  input operator_code, input result_value, input entry_value,
                  output ready);
endinterface

/* hdl/keypad_four_function_calculator.sv */
// Keypad four-function calculator.
//
// in_key carries one decoded key code per beat (valid/ready). Digit keys
// (1..9, 10 for zero) shift a decimal digit into the entry register; with a
// nonzero entry, keys 11..14 latch add/sub/mul/div and move it into the
// accumulator and key 15 applies a pending operator to both. Everything
// wraps modulo 2^VALUE_WIDTH. Every key gives exactly one beat on out_res with
// the event kind, the digit, the pending operator, accumulator and entry.
//
// Flow: digit and acting equals keys run through a bit-serial unit that
// takes one bit per cycle, then pass the done state and the output register;
// other keys pass only the done state and the output register.
// One key is in flight at a time; in_key.ready is high whenever no key is in
// flight, so a new key is taken only once the last one has been committed.
//
// Reset (synchronous, active low) clears entry, accumulator and operator and
// drops out_res.valid. A stalled receiver holds the output register; the
// finished key waits in the commit stage and in_key stays blocked meanwhile.
module keypad_four_function_calculator import kfc_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  kfc_key_if.sink   in_key,
  kfc_res_if.source out_res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t state_r;

  // architectural state
  logic [VALUE_WIDTH-1:0] entry_r;
  logic [VALUE_WIDTH-1:0] acc_r;
  logic [2:0]             op_r;

  // staged outcome of the key in flight
  logic [1:0]             stg_kind_r;
  logic [3:0]             stg_digit_r;
  logic [VALUE_WIDTH-1:0] stg_entry_r;
  logic [VALUE_WIDTH-1:0] stg_acc_r;
  logic [2:0]             stg_op_r;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [3:0]  out_digit_r;
  logic [2:0]  out_op_r;
  logic [15:0] out_acc_r;
  logic [15:0] out_entry_r;

  logic [7:0]             key;
  logic                   in_fire;
  logic                   is_digit, is_oper, is_eq, ent_nz, eq_go;
  logic [3:0]             digit;
  logic [2:0]             new_op;
  alu_op_t                eq_alu_op;
  alu_cmd_t               alu_cmd;
  alu_sts_t               alu_sts;
  logic [VALUE_WIDTH-1:0] alu_a, alu_b, alu_p, alu_res;

  assign key     = in_key.key_code;
  assign in_fire = in_key.valid && in_key.ready;

  // Decode the key against the committed state.
  always_comb begin
    is_digit = (key >= KEY_ONE) && (key <= KEY_ZERO);
    is_oper  = (key >= KEY_ADD) && (key < KEY_EQUALS);
    is_eq    = (key == KEY_EQUALS);
    ent_nz   = (entry_r != '0);
    eq_go    = is_eq && ent_nz && (op_r != OP_NONE);
    digit    = (key == KEY_ZERO) ? 4'd0 : key[3:0];
    new_op   = 3'(key - KEY_ADD) + OP_ADD;

    unique case (op_r)
      OP_ADD:  eq_alu_op = ALU_ADD;
      OP_SUB:  eq_alu_op = ALU_SUB;
      OP_MUL:  eq_alu_op = ALU_MAC;
      default: eq_alu_op = ALU_DIV;
    endcase

    // digit append is entry*10 + digit on the multiply-accumulate path
    alu_cmd.start = in_fire && (is_digit || eq_go);
    alu_cmd.op    = is_digit ? ALU_MAC : eq_alu_op;
    alu_a         = is_digit ? entry_r : acc_r;
    alu_b         = is_digit ? TEN : entry_r;
    alu_p         = is_digit ? VALUE_WIDTH'(digit) : '0;
  end

  kfc_serial_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (alu_cmd),
    .a      (alu_a),
    .b      (alu_b),
    .p_init (alu_p),
    .sts    (alu_sts),
    .result (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      entry_r     <= '0;
      acc_r       <= '0;
      op_r        <= OP_NONE;
    end else begin
      // drop the beat once taken; the done state reloads the slot itself
      if (out_valid_r && out_res.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (is_digit) begin
              stg_kind_r  <= EV_DIGIT;
              stg_digit_r <= digit;
              stg_entry_r <= entry_r;
              stg_acc_r   <= acc_r;
              stg_op_r    <= op_r;
            end else if (is_oper && ent_nz) begin
              stg_kind_r  <= EV_OPER;
              stg_digit_r <= 4'd0;
              stg_entry_r <= '0;
              stg_acc_r   <= entry_r;
              stg_op_r    <= new_op;
            end else if (eq_go) begin
              stg_kind_r  <= EV_RESULT;
              stg_digit_r <= 4'd0;
              stg_entry_r <= '0;
              stg_acc_r   <= acc_r;
              stg_op_r    <= op_r;
            end else begin
              stg_kind_r  <= EV_IGNORED;
              stg_digit_r <= 4'd0;
              stg_entry_r <= entry_r;
              stg_acc_r   <= acc_r;
              stg_op_r    <= op_r;
            end
            state_r <= alu_cmd.start ? S_RUN : S_DONE;
          end
        end
        S_RUN: begin
          if (alu_sts.done) begin
            if (stg_kind_r == EV_DIGIT) begin
              stg_entry_r <= alu_res;
            end else begin
              stg_acc_r <= alu_res;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // commit state and load the output once the slot is free
          if (!out_valid_r || out_res.ready) begin
            entry_r     <= stg_entry_r;
            acc_r       <= stg_acc_r;
            op_r        <= stg_op_r;
            out_valid_r <= 1'b1;
            out_kind_r  <= stg_kind_r;
            out_digit_r <= stg_digit_r;
            out_op_r    <= stg_op_r;
            out_acc_r   <= fit16(stg_acc_r);
            out_entry_r <= fit16(stg_entry_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_key.ready          = (state_r == S_IDLE);
  assign out_res.valid         = out_valid_r;
  assign out_res.event_kind    = out_kind_r;
  assign out_res.shown_digit   = out_digit_r;
  assign out_res.operator_code = out_op_r;
  assign out_res.result_value  = out_acc_r;
  assign out_res.entry_value   = out_entry_r;

  // The serial unit runs only while a key waits on it.
  a_alu_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (alu_sts.busy || alu_sts.done) |-> (state_r == S_RUN))
    else $error("serial unit active outside the run state");

  // An operator latch or a computed result always leaves a cleared entry.
  a_entry_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && (out_res.event_kind == EV_OPER || out_res.event_kind == EV_RESULT))
      |-> (out_res.entry_value == 16'd0 && out_res.operator_code != OP_NONE))
    else $error("operator or result beat without cleared entry");

  // An accepted key always leaves the idle state on the next edge.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("accepted key did not start");

endmodule

/* hdl/kfc_serial_alu.sv */
module kfc_serial_alu import kfc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  alu_cmd_t               cmd,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  input  logic [VALUE_WIDTH-1:0] p_init,
  output alu_sts_t               sts,
  output logic [VALUE_WIDTH-1:0] result
);

  logic                   busy_r;
  logic                   done_r;
  alu_op_t                op_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [VALUE_WIDTH-1:0] a_r, a_nxt;
  logic [VALUE_WIDTH-1:0] b_r, b_nxt;
  logic [VALUE_WIDTH-1:0] p_r, p_nxt;
  logic                   c_r, c_nxt;

  logic [VALUE_WIDTH:0]   rem_sh;
  logic [VALUE_WIDTH+1:0] diff;
  logic                   sum_bit;

  // One step of the selected operation.
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    p_nxt   = p_r;
    c_nxt   = c_r;
    rem_sh  = {p_r, a_r[VALUE_WIDTH-1]};
    diff    = {1'b0, rem_sh} - {2'b0, b_r};
    sum_bit = a_r[0] ^ b_r[0] ^ c_r;
    unique case (op_r)
      ALU_MAC: begin
        if (b_r[0]) begin
          p_nxt = p_r + a_r;
        end
        a_nxt = {a_r[VALUE_WIDTH-2:0], 1'b0};
        b_nxt = {1'b0, b_r[VALUE_WIDTH-1:1]};
      end
      ALU_ADD, ALU_SUB: begin
        p_nxt = {sum_bit, p_r[VALUE_WIDTH-1:1]};
        c_nxt = (a_r[0] & b_r[0]) | (a_r[0] & c_r) | (b_r[0] & c_r);
        a_nxt = {1'b0, a_r[VALUE_WIDTH-1:1]};
        b_nxt = {1'b0, b_r[VALUE_WIDTH-1:1]};
      end
      ALU_DIV: begin
        // restoring step: remainder in p_r, dividend/quotient in a_r
        if (diff[VALUE_WIDTH+1]) begin
          p_nxt = rem_sh[VALUE_WIDTH-1:0];
        end else begin
          p_nxt = diff[VALUE_WIDTH-1:0];
        end
        a_nxt = {a_r[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH+1]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // pulse done for one cycle after the last step
      done_r <= busy_r && !cmd.start && (cnt_r == '0);
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(VALUE_WIDTH - 1);
        op_r   <= cmd.op;
        a_r    <= a;
        b_r    <= (cmd.op == ALU_SUB) ? ~b : b;
        p_r    <= (cmd.op == ALU_MAC) ? p_init : '0;
        c_r    <= (cmd.op == ALU_SUB);
      end else if (busy_r) begin
        a_r   <= a_nxt;
        b_r   <= b_nxt;
        p_r   <= p_nxt;
        c_r   <= c_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = (op_r == ALU_DIV) ? a_r : p_r;

endmodule
